[rtl/srtab_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srtab_pkg
// Shared types and codes for the sorted region table allocator.
// ----------------------------------------------------------------------------
package srtab_pkg;

   // Item command codes.
   typedef enum logic {
      CMD_FIND   = 1'b0,
      CMD_INSERT = 1'b1
   } cmd_type;

   // Result status codes.
   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_NO_SPACE = 2'd1,
      STATUS_OVERLAP  = 2'd2,
      STATUS_FULL     = 2'd3
   } status_type;

   // Configuration register indexes.
   localparam int CSR_IDX_BITS = 1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MAP_START = 1'b0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MAP_END   = 1'b1;

   // Sequencer states.
   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SCAN  = 4'b0010,
      ST_SHIFT = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

endpackage

[rtl/sorted_region_table_first_fit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_region_table_first_fit
// A find ends its scan at the first entry that starts at or past its candidate run's end;
//    an insert that fits scans the whole table and then moves up the entries at and above
//    its sorted slot pos, when there are any, before it places the new region.
// Throughput: one item at a time; the table memory is streamed one entry per cycle,
//    first by the scan and then, for an insert, by the shift-up pass.
// Reset clears the region count and sets the window registers to the whole page space; the
//    table memory itself is not cleared, since only entries below the count are read.
// ----------------------------------------------------------------------------
module sorted_region_table_first_fit #(
   parameter int MAX_REGIONS = 64,
   parameter int PAGE_BITS   = 20
) (
   input  logic                                clock,
   input  logic                                reset,
   // Item channel.
   input  logic                                req_valid,
   output logic                                req_stall,
   input  srtab_pkg::cmd_type                  req_command,
   input  logic [PAGE_BITS:0]                  req_page_count,
   input  logic [PAGE_BITS-1:0]                req_region_start,
   // Result channel.
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output srtab_pkg::status_type               rsp_status,
   output logic [PAGE_BITS-1:0]                rsp_found_page,
   // Configuration write channel.
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [srtab_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [PAGE_BITS:0]                  csr_data
);
   import srtab_pkg::*;

   localparam int PW = PAGE_BITS;
   localparam int SW = PAGE_BITS + 2;
   localparam int CW = $clog2(MAX_REGIONS + 1);
   localparam int AW = $clog2(MAX_REGIONS);
   localparam int EW = 2 * PAGE_BITS + 1;
   localparam logic [PW:0] PAGE_SPACE = {1'b1, {PW{1'b0}}};
   localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_REGIONS);

   // Region table: {start, end} per entry.
   logic [EW-1:0] mem [MAX_REGIONS];
   logic [EW-1:0] rd_data_ff;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic          mem_we;
   logic [AW-1:0] wr_addr;
   logic [EW-1:0] wr_data;

   // Sequencer registers.
   state_type   state_ff, state_in;
   cmd_type     cmd_ff, cmd_in;
   logic [PW:0] n_ff, n_in;
   logic [PW-1:0] start_ff, start_in;
   logic [PW:0] end_ff, end_in;
   logic [PW:0] s_ff, s_in;
   status_type  status_ff, status_in;
   logic [CW-1:0] iss_ff, iss_in;
   logic        dv_ff, dv_in;
   logic [CW-1:0] pos_ff, pos_in;
   logic [CW-1:0] rdi_ff, rdi_in;
   logic [AW-1:0] wr_ff, wr_in;
   logic [CW-1:0] count_ff, count_in;
   logic [PW:0] map_start_ff, map_end_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   status_type  rsp_status_ff, rsp_status_in;
   logic [PW-1:0] rsp_page_ff, rsp_page_in;

   // Derived values.
   logic [PW:0]   hi;
   logic          accept;
   logic [SW-1:0] req_find_sum;
   logic [SW-1:0] req_ins_sum;
   logic          req_reject;
   logic [PW-1:0] e_start;
   logic [PW:0]   e_end;
   logic [SW-1:0] sn;
   logic          brk, meet, ov, lt, last;
   logic          rsp_free;
   status_type    final_status;

   // Table memory with registered read.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // Configuration writes are always taken.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         map_start_ff <= '0;
         map_end_ff   <= PAGE_SPACE;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_MAP_START: map_start_ff <= csr_data;
            CSR_MAP_END:   map_end_ff   <= csr_data;
            default:       ;
         endcase
      end
   end

   // Window end clipped to the page space.
   assign hi = (map_end_ff < PAGE_SPACE) ? map_end_ff : PAGE_SPACE;

   // Checks made directly on the incoming item.
   assign accept       = req_valid && (state_ff == ST_IDLE);
   assign req_stall    = (state_ff != ST_IDLE);
   assign req_find_sum = {1'b0, map_start_ff} + {1'b0, req_page_count};
   assign req_ins_sum  = {2'b00, req_region_start} + {1'b0, req_page_count};
   always_comb begin
      if (req_command == CMD_FIND) begin
         req_reject = (req_page_count == '0) || (req_find_sum > {1'b0, hi});
      end else begin
         req_reject = (req_page_count == '0) || (req_ins_sum > {1'b0, PAGE_SPACE});
      end
   end

   // Entry compare against the current candidate or the new region.
   assign e_start = rd_data_ff[EW-1 -: PW];
   assign e_end   = rd_data_ff[PW:0];
   assign sn      = {1'b0, s_ff} + {1'b0, n_ff};
   assign brk     = {2'b00, e_start} >= sn;
   assign meet    = (s_ff < e_end) && ({2'b00, e_start} < sn);
   assign ov      = (e_start == start_ff) ||
                    (({1'b0, start_ff} < e_end) && ({1'b0, e_start} < end_ff));
   assign lt      = e_start < start_ff;
   assign last    = (iss_ff == count_ff);

   // Final status, including the window-end check on a find.
   always_comb begin
      final_status = status_ff;
      if ((cmd_ff == CMD_FIND) && (status_ff == STATUS_OK) && (sn > {1'b0, hi})) begin
         final_status = STATUS_NO_SPACE;
      end
   end

   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   // Sequencer.
   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      n_in          = n_ff;
      start_in      = start_ff;
      end_in        = end_ff;
      s_in          = s_ff;
      status_in     = status_ff;
      iss_in        = iss_ff;
      dv_in         = dv_ff;
      pos_in        = pos_ff;
      rdi_in        = rdi_ff;
      wr_in         = wr_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_page_in   = rsp_page_ff;
      rd_en         = 1'b0;
      rd_addr       = AW'(iss_ff);
      mem_we        = 1'b0;
      wr_addr       = wr_ff;
      wr_data       = rd_data_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd_in   = req_command;
               n_in     = req_page_count;
               start_in = req_region_start;
               end_in   = req_ins_sum[PW:0];
               s_in     = map_start_ff;
               iss_in   = '0;
               dv_in    = 1'b0;
               pos_in   = '0;
               rdi_in   = count_ff;
               if (req_reject) begin
                  status_in = STATUS_NO_SPACE;
                  state_in  = ST_DONE;
               end else if (count_ff != '0) begin
                  status_in = STATUS_OK;
                  state_in  = ST_SCAN;
               end else if (req_command == CMD_FIND) begin
                  status_in = STATUS_OK;
                  state_in  = ST_DONE;
               end else begin
                  status_in = STATUS_OK;
                  state_in  = ST_SHIFT;
               end
            end
         end

         ST_SCAN: begin
            // Stream the next read while the previous entry is evaluated.
            if (iss_ff < count_ff) begin
               rd_en  = 1'b1;
               iss_in = iss_ff + 1'b1;
               dv_in  = 1'b1;
            end else begin
               dv_in  = 1'b0;
            end
            if (dv_ff) begin
               if (cmd_ff == CMD_FIND) begin
                  if (brk) begin
                     dv_in    = 1'b0;
                     state_in = ST_DONE;
                  end else begin
                     if (meet) begin
                        s_in = e_end;
                     end
                     if (last) begin
                        state_in = ST_DONE;
                     end
                  end
               end else begin
                  if (ov) begin
                     status_in = STATUS_OVERLAP;
                     dv_in     = 1'b0;
                     state_in  = ST_DONE;
                  end else begin
                     if (lt) begin
                        pos_in = pos_ff + 1'b1;
                     end
                     if (last) begin
                        if (count_ff == MAX_COUNT) begin
                           status_in = STATUS_FULL;
                           state_in  = ST_DONE;
                        end else begin
                           rdi_in   = count_ff;
                           state_in = ST_SHIFT;
                        end
                     end
                  end
               end
            end
         end

         ST_SHIFT: begin
            // Move entries up by one from the top down, then place the new one.
            rd_addr = AW'(rdi_ff - 1'b1);
            if (rdi_ff > pos_ff) begin
               rd_en  = 1'b1;
               wr_in  = AW'(rdi_ff);
               rdi_in = rdi_ff - 1'b1;
            end
            dv_in = rd_en;
            if (dv_ff) begin
               mem_we  = 1'b1;
               wr_addr = wr_ff;
               wr_data = rd_data_ff;
            end else if (!rd_en) begin
               mem_we    = 1'b1;
               wr_addr   = AW'(pos_ff);
               wr_data   = {start_ff, end_ff};
               count_in  = count_ff + 1'b1;
               status_in = STATUS_OK;
               state_in  = ST_DONE;
            end
         end

         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = final_status;
               if ((cmd_ff == CMD_FIND) && (final_status == STATUS_OK)) begin
                  rsp_page_in = s_ff[PW-1:0];
               end else begin
                  rsp_page_in = '0;
               end
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         dv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dv_ff        <= dv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      n_ff          <= n_in;
      start_ff      <= start_in;
      end_ff        <= end_in;
      s_ff          <= s_in;
      status_ff     <= status_in;
      iss_ff        <= iss_in;
      pos_ff        <= pos_in;
      rdi_ff        <= rdi_in;
      wr_ff         <= wr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_page_ff   <= rsp_page_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_found_page = rsp_page_ff;

   // The region count never exceeds the table depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= MAX_COUNT)
      else $error("region count exceeds table depth");

   // Only a successful find reports a page.
   a_page_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != STATUS_OK)) |-> (rsp_found_page == '0))
      else $error("page reported without a successful find");

   // The shift pass never reads the entry it is writing.
   a_shift_no_clash: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SHIFT) && mem_we && rd_en) |-> (wr_addr != rd_addr))
      else $error("shift pass read and write collide");

   // The count only grows, by one, when an insert places its region.
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (count_ff != $past(count_ff))) |->
         (($past(state_ff) == ST_SHIFT) && (count_ff == $past(count_ff) + 1'b1)))
      else $error("region count changed outside an insert");

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives find and insert commands into the first-fit region table, with
// random pauses on both channels. A behavioral copy of the table predicts
// every result, and each result is checked field by field in arrival order.
// ----------------------------------------------------------------------------
module testbench;
   import srtab_pkg::*;

   localparam int MAX_REGIONS = 64;
   localparam logic [21:0] PAGE_SPACE = 22'h100000;
   localparam int DRAIN_CYCLES = 8;
   localparam int IDLE_LIMIT = 1000;
   localparam int RANDOM_PHASES = 6;
   localparam int PHASE_ITEMS = 260;

   typedef struct packed {
      cmd_type     cmd;
      logic [20:0] count;
      logic [19:0] start;
   } cmd_item_type;

   typedef struct packed {
      status_type  status;
      logic [19:0] page;
   } answer_type;

   typedef struct packed {
      logic [19:0] lo_page;
      logic [20:0] end_page;
   } region_type;

   // Block ports; the inputs are known from time zero.
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   cmd_type     req_command = CMD_FIND;
   logic [20:0] req_page_count = '0;
   logic [19:0] req_region_start = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   status_type  rsp_status;
   logic [19:0] rsp_found_page;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [CSR_IDX_BITS-1:0] csr_index = CSR_MAP_START;
   logic [20:0] csr_data = '0;

   // Predicted table state and window registers.
   region_type  region_tab[$];
   logic [20:0] win_lo = 21'h0;
   logic [20:0] win_hi = 21'h100000;

   cmd_item_type cmd_backlog[$];
   answer_type  pending_answers[$];
   cmd_item_type live_item;
   bit          sending = 1'b0;
   bit          req_took = 1'b0;
   bit          rsp_took = 1'b0;
   int          send_gap = 0;
   int          rx_hold = 0;
   int          quiet_left[2] = '{0, 0};
   int          quiet_cycles = 0;
   bit          mismatch_seen = 1'b0;

   sorted_region_table_first_fit uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_page_count   (req_page_count),
      .req_region_start (req_region_start),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_found_page   (rsp_found_page),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Pause length for one side; now and then a stretch with no pauses at all.
   function automatic int draw_pause(input int side);
      if (quiet_left[side] > 0) begin
         quiet_left[side]--;
         return 0;
      end
      if ($urandom_range(0, 24) == 0) begin
         quiet_left[side] = $urandom_range(15, 60);
         return 0;
      end
      return $urandom_range(0, 12);
   endfunction

   // Computes the answer to one command and updates the predicted table.
   function automatic answer_type table_answer(input cmd_item_type it);
      answer_type  ans;
      region_type  nr;
      logic [21:0] lo, hi, s, n, stop;
      bit          clash;
      int          pos;
      ans.status = STATUS_OK;
      ans.page = '0;
      n = {1'b0, it.count};
      if (it.cmd == CMD_FIND) begin
         lo = {1'b0, win_lo};
         hi = (win_hi < PAGE_SPACE) ? {1'b0, win_hi} : PAGE_SPACE;
         s = lo;
         if (n == 0 || lo + n > hi) begin
            ans.status = STATUS_NO_SPACE;
         end else begin
            // First fit: hop past every stored region that meets the candidate run.
            for (int i = 0; i < region_tab.size(); i++) begin
               if (region_tab[i].lo_page >= s + n) break;
               if (s < region_tab[i].end_page && region_tab[i].lo_page < s + n)
                  s = {1'b0, region_tab[i].end_page};
            end
            if (s + n > hi) ans.status = STATUS_NO_SPACE;
            else ans.page = s[19:0];
         end
      end else begin
         stop = {2'b00, it.start} + n;
         clash = 1'b0;
         foreach (region_tab[i]) begin
            if (region_tab[i].lo_page == it.start ||
                (it.start < region_tab[i].end_page && region_tab[i].lo_page < stop))
               clash = 1'b1;
         end
         if (n == 0 || stop > PAGE_SPACE) begin
            ans.status = STATUS_NO_SPACE;
         end else if (clash) begin
            ans.status = STATUS_OVERLAP;
         end else if (region_tab.size() >= MAX_REGIONS) begin
            ans.status = STATUS_FULL;
         end else begin
            pos = 0;
            while (pos < region_tab.size() && region_tab[pos].lo_page < it.start) pos++;
            nr.lo_page = it.start;
            nr.end_page = stop[20:0];
            region_tab.insert(pos, nr);
         end
      end
      return ans;
   endfunction

   // Monitor: predicts on each accepted command and checks each result.
   always @(posedge clock) begin : monitor
      answer_type want;
      req_took = 1'b0;
      rsp_took = 1'b0;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_MAP_START: win_lo = csr_data;
               CSR_MAP_END:   win_hi = csr_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            req_took = 1'b1;
            pending_answers.push_back(table_answer(live_item));
         end
         if (rsp_valid && !rsp_stall) begin
            rsp_took = 1'b1;
            if (pending_answers.size() == 0) begin
               $display("%0t: result with nothing expected, status %0d page %0d",
                        $time, rsp_status, rsp_found_page);
               mismatch_seen = 1'b1;
            end else begin
               want = pending_answers.pop_front();
               if (rsp_status !== want.status) begin
                  $display("%0t: status expected %0d, actual %0d",
                           $time, want.status, rsp_status);
                  mismatch_seen = 1'b1;
               end
               if (rsp_found_page !== want.page) begin
                  $display("%0t: found_page expected %0d, actual %0d",
                           $time, want.page, rsp_found_page);
                  mismatch_seen = 1'b1;
               end
            end
         end
      end
   end

   // Driver: presents queued commands, with a random gap after each transfer.
   always @(negedge clock) begin : sender
      if (req_took) begin
         sending = 1'b0;
         send_gap = draw_pause(0);
      end
      if (!sending && cmd_backlog.size() != 0) begin
         if (send_gap > 0) begin
            send_gap--;
         end else begin
            live_item = cmd_backlog.pop_front();
            sending = 1'b1;
            req_command <= live_item.cmd;
            req_page_count <= live_item.count;
            req_region_start <= live_item.start;
         end
      end
      req_valid <= sending;
   end

   // Result side: stalls for a random number of cycles after each transfer.
   always @(negedge clock) begin : receiver
      if (rsp_took) rx_hold = draw_pause(1);
      if (rx_hold > 0) begin
         rsp_stall <= 1'b1;
         rx_hold--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Watchdog on cycles without any transfer.
   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
         $display("Mismatches found");
         $finish;
      end else begin
         quiet_cycles++;
      end
   end

   task automatic queue_item(input cmd_type cmd, input logic [20:0] count,
                             input logic [19:0] start);
      cmd_item_type it;
      it.cmd = cmd;
      it.count = count;
      it.start = start;
      cmd_backlog.push_back(it);
   endtask

   // Waits until every command is sent and every result has come back.
   task automatic settle();
      while (cmd_backlog.size() != 0 || sending || pending_answers.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_BITS-1:0] idx, input logic [20:0] val);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Drains the block, sets a new window and returns on a rising edge.
   task automatic open_phase(input logic [20:0] lo, input logic [20:0] hi);
      settle();
      write_csr(CSR_MAP_START, lo);
      write_csr(CSR_MAP_END, hi);
      @(posedge clock);
   endtask

   initial begin : stimulus
      logic [20:0] lo, hi, count;
      logic [19:0] start, p;
      region_type  r;
      int          sel, d, need;
      bit          taken;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: field extremes, page space edge, overlaps and first-fit skips.
      open_phase(21'h0, 21'h100000);
      queue_item(CMD_FIND, 21'd0, 20'd0);
      queue_item(CMD_INSERT, 21'd0, 20'd5);
      queue_item(CMD_FIND, 21'd1, 20'hFFFFF);
      queue_item(CMD_FIND, 21'h100000, 20'd0);
      queue_item(CMD_FIND, 21'h1FFFFF, 20'd0);
      queue_item(CMD_INSERT, 21'd1, 20'hFFFFF);
      queue_item(CMD_INSERT, 21'd2, 20'hFFFFF);
      queue_item(CMD_INSERT, 21'd2, 20'hFFFFE);
      queue_item(CMD_INSERT, 21'd16, 20'd0);
      queue_item(CMD_INSERT, 21'd1, 20'd0);
      queue_item(CMD_INSERT, 21'd4, 20'd8);
      queue_item(CMD_INSERT, 21'd16, 20'd16);
      queue_item(CMD_FIND, 21'd1, 20'd0);
      queue_item(CMD_INSERT, 21'd50, 20'd100);
      queue_item(CMD_FIND, 21'd68, 20'd0);
      queue_item(CMD_FIND, 21'd69, 20'd0);
      queue_item(CMD_FIND, 21'h100000, 20'd0);
      queue_item(CMD_INSERT, 21'd10, 20'd40);
      queue_item(CMD_FIND, 21'd8, 20'd0);
      queue_item(CMD_INSERT, 21'h1FFFFF, 20'h80000);

      // Inverted window, then a window that starts at the end of page space.
      open_phase(21'h1FFFFF, 21'h0);
      queue_item(CMD_FIND, 21'd1, 20'd0);
      queue_item(CMD_FIND, 21'h100000, 20'd0);
      queue_item(CMD_INSERT, 21'd3, 20'h12345);
      open_phase(21'h100000, 21'h1FFFFF);
      queue_item(CMD_FIND, 21'd1, 20'd0);
      queue_item(CMD_FIND, 21'h1FFFFF, 20'hFFFFF);

      // Random phases, mostly finds over a crowded low area of page space.
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         case (ph)
            0: begin lo = 21'h0; hi = 21'h100000; end
            1: begin
               lo = 21'($urandom_range(0, 16383));
               hi = lo + 21'($urandom_range(256, 20000));
            end
            2: begin lo = 21'($urandom_range(0, 16383)); hi = 21'h1FFFFF; end
            3: begin
               lo = 21'($urandom_range(0, 16383));
               hi = lo + 21'($urandom_range(1, 64));
            end
            4: begin lo = 21'($urandom_range(0, 1048575)); hi = 21'h100000; end
            default: begin
               lo = 21'($urandom_range(0, 8191));
               hi = 21'($urandom_range(0, 16384));
            end
         endcase
         open_phase(lo, hi);
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            start = 20'($urandom());
            if ($urandom_range(0, 99) < 8) begin
               if (region_tab.size() != 0 && $urandom_range(0, 1) == 1) begin
                  // Aimed at a stored region: equal start or straddling its base.
                  r = region_tab[$urandom_range(0, region_tab.size() - 1)];
                  d = $urandom_range(0, 7);
                  if (d > r.lo_page) d = int'(r.lo_page);
                  start = 20'(r.lo_page - d);
                  count = 21'(d + $urandom_range(1, 16));
               end else begin
                  sel = $urandom_range(0, 15);
                  if (sel == 0) begin
                     count = 21'($urandom_range(0, 21'h1FFFFF));
                  end else if (sel == 1) begin
                     count = 21'd0;
                  end else begin
                     start = 20'($urandom_range(0, 16383));
                     count = 21'($urandom_range(1, 48));
                  end
               end
               queue_item(CMD_INSERT, count, start);
            end else begin
               sel = $urandom_range(0, 49);
               if (sel == 0) count = 21'd0;
               else if (sel < 4) count = 21'($urandom_range(0, 21'h1FFFFF));
               else if (sel < 12) count = 21'($urandom_range(1, 4096));
               else count = 21'($urandom_range(1, 128));
               queue_item(CMD_FIND, count, start);
            end
         end
      end

      // Fill the table to capacity on free single pages, then push past it.
      open_phase(21'h0, 21'h100000);
      need = MAX_REGIONS - region_tab.size() + 2;
      p = 20'h40000;
      while (need > 0 && p < 20'hFFFF0) begin
         taken = 1'b0;
         foreach (region_tab[i]) begin
            if (region_tab[i].lo_page <= p && p < region_tab[i].end_page) taken = 1'b1;
         end
         if (!taken) begin
            queue_item(CMD_INSERT, 21'd1, p);
            need--;
         end
         p = p + 20'd2;
      end
      // Overlap is reported ahead of a full table.
      if (region_tab.size() != 0) queue_item(CMD_INSERT, 21'd1, region_tab[0].lo_page);
      for (int k = 0; k < 30; k++) begin
         queue_item(CMD_FIND, 21'($urandom_range(1, 2048)), 20'($urandom()));
      end

      settle();
      if (!mismatch_seen) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/srtab_pkg.sv
rtl/sorted_region_table_first_fit.sv
tb/testbench.sv
